@@ hw/rtl/rra_pkg.sv @@
package rra_pkg;

	localparam int MAX_STATIONS = 1024;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int CNT_W = $clog2(MAX_STATIONS + 1);
	// sum of up to MAX_STATIONS signed 32-bit readings
	localparam int SUM_W = DATA_W + ADDR_W;
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] temperature;
		logic signed [DATA_W-1:0] query_x_low;
		logic signed [DATA_W-1:0] query_y_low;
		logic signed [DATA_W-1:0] query_x_high;
		logic signed [DATA_W-1:0] query_y_high;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] average;
		logic [CNT_W-1:0] matched_count;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] temp;
	} station_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		station_t data;
	} st_wr_t;

	typedef struct packed {
		logic start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [DATA_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/rectangle_range_average_top.sv @@
// Channel   Handshake         Payload    Notes
// command   start / busy      cmd        taken when start high and busy low
// result    done (strobe)     result     valid for the done cycle only
//
// For a load the point is written at the accepting edge and busy stays low. A
// query scans every stored point through the store's single read port, one per
// cycle, then, if any point matched, runs a one-bit-per-cycle divider over the
// 42-bit sum. Reset clears the point count and the sequencer; the store itself
// is not cleared. The receiver cannot stall: done pulses for exactly one cycle.
module rectangle_range_average_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input rra_pkg::cmd_t cmd,
	output logic done,
	output rra_pkg::result_t result
);
	import rra_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] matched_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [DATA_W-1:0] avg_q;
	logic signed [DATA_W-1:0] xl_q, yl_q, xh_q, yh_q;

	logic accept;
	logic rd_en;
	logic div_start;
	logic rd_vld_s1;
	logic cmp_vld_s2;
	logic hit_s2;
	logic signed [DATA_W-1:0] temp_s2;
	logic hit;
	logic last;

	st_wr_t wr;
	station_t rd_data;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign last = (idx_q == cnt_q - CNT_W'(1));

	assign wr.en = accept && (cmd.op == OP_LOAD) && (cnt_q < CNT_W'(MAX_STATIONS));
	assign wr.addr = cnt_q[ADDR_W-1:0];
	assign wr.data.x = cmd.point_x;
	assign wr.data.y = cmd.point_y;
	assign wr.data.temp = cmd.temperature;

	rra_store u_store (
		.clk(clk),
		.wr(wr),
		.rd_en(rd_en),
		.rd_addr(idx_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	assign div_req = '{start: div_start, dividend: sum_q, divisor: matched_q};

	rra_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign hit = ($signed(rd_data.x) >= xl_q) && ($signed(rd_data.x) <= xh_q) &&
		($signed(rd_data.y) >= yl_q) && ($signed(rd_data.y) <= yh_q);

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		div_start = 1'b0;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.op == OP_QUERY) begin
					state_d = (cnt_q == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !cmp_vld_s2) begin
					if (matched_q == '0) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			cmp_vld_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_en;
			cmp_vld_s2 <= rd_vld_s1;
			if (wr.en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.op == OP_QUERY) begin
			xl_q <= cmd.query_x_low;
			yl_q <= cmd.query_y_low;
			xh_q <= cmd.query_x_high;
			yh_q <= cmd.query_y_high;
			idx_q <= '0;
			matched_q <= '0;
			sum_q <= '0;
		end else begin
			if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			// accumulate points inside the rectangle
			if (cmp_vld_s2 && hit_s2) begin
				matched_q <= matched_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(temp_s2);
			end
		end
		if (rd_vld_s1) begin
			hit_s2 <= hit;
			temp_s2 <= rd_data.temp;
		end
		if (state_q == ST_DRAIN && state_d == ST_DONE) begin
			avg_q <= '0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			avg_q <= div_rsp.quotient;
		end
	end

	assign result.average = avg_q;
	assign result.matched_count = matched_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rd_vld_s1 && !cmp_vld_s2)
		else $error("scan pipeline busy while idle");
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_STATIONS))
		else $error("point count beyond capacity");
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.matched_count <= cnt_q)
		else $error("matched count exceeds stored points");

endmodule

@@ hw/rtl/rra_store.sv @@
module rra_store (
	input logic clk,
	input rra_pkg::st_wr_t wr,
	input logic rd_en,
	input logic [rra_pkg::ADDR_W-1:0] rd_addr,
	output rra_pkg::station_t rd_data
);
	import rra_pkg::*;

	station_t mem [MAX_STATIONS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/rra_div.sv @@
module rra_div (
	input logic clk,
	input logic arst_n,
	input rra_pkg::div_req_t req,
	output rra_pkg::div_rsp_t rsp
);
	import rra_pkg::*;

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] dv_q;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [SUM_W-1:0] mag;
	logic [CNT_W:0] trial;
	logic ge;
	logic [SUM_W-1:0] quo_signed;

	assign mag = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge = (trial >= {1'b0, dv_q});
	assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			dv_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, dv_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_signed[DATA_W-1:0];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && !$past(done_q))
		else $error("divider done overlaps iteration");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_W'(SUM_W - 1))
		else $error("divider step count out of range");

endmodule

@@ verif/rectangle_range_average_top_tb.sv @@
module rectangle_range_average_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rra_pkg::*;

	localparam int COORD_MIN = 32'h8000_0000;
	localparam int COORD_MAX = 32'h7fff_ffff;
	localparam int RANDOM_ITEMS = 470;
	localparam int CLOSING_QUERIES = 40;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		cmd_t c;
		bit has_fixed;
		result_t fixed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	result_t result;

	// shadow copy of the station table
	int known_x[MAX_STATIONS];
	int known_y[MAX_STATIONS];
	int known_temp[MAX_STATIONS];
	int known_count;

	result_t awaited_results[$];
	int mismatch_count;
	stim_row_t directed_rows[$];

	rectangle_range_average_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always begin
		#1ns clk = 1'b1;
		#1ns clk = 1'b0;
	end

	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return int'($urandom);
			default: return int'($urandom_range(0, 16)) - 8;
		endcase
	endfunction

	function automatic int rand_temp();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return int'($urandom);
			4: return COORD_MIN;
			5: return COORD_MAX;
			default: return int'($urandom_range(0, 200)) - 100;
		endcase
	endfunction

	// query fields of a load and point fields of a query carry noise
	function automatic cmd_t load_cmd(input int x, input int y, input int t);
		cmd_t c;
		c.op = OP_LOAD;
		c.point_x = x;
		c.point_y = y;
		c.temperature = t;
		c.query_x_low = $urandom;
		c.query_y_low = $urandom;
		c.query_x_high = $urandom;
		c.query_y_high = $urandom;
		return c;
	endfunction

	function automatic cmd_t query_cmd(input int xl, input int yl, input int xh, input int yh);
		cmd_t c;
		c.op = OP_QUERY;
		c.point_x = $urandom;
		c.point_y = $urandom;
		c.temperature = $urandom;
		c.query_x_low = xl;
		c.query_y_low = yl;
		c.query_x_high = xh;
		c.query_y_high = yh;
		return c;
	endfunction

	function automatic cmd_t rand_query();
		int a;
		int b;
		int p;
		int q;
		a = int'($urandom_range(0, 16)) - 8;
		b = int'($urandom_range(0, 16)) - 8;
		p = int'($urandom_range(0, 16)) - 8;
		q = int'($urandom_range(0, 16)) - 8;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5:
				return query_cmd(a < b ? a : b, p < q ? p : q, a < b ? b : a, p < q ? q : p);
			6, 7: return query_cmd(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			8: return query_cmd(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
			default: return query_cmd(a > b ? a : b, p, a > b ? b : a, q);
		endcase
	endfunction

	function automatic stim_row_t load_row(input int x, input int y, input int t);
		stim_row_t r;
		r.c = load_cmd(x, y, t);
		r.has_fixed = 1'b0;
		r.fixed = '0;
		return r;
	endfunction

	function automatic stim_row_t query_row(input int xl, input int yl, input int xh,
			input int yh, input bit has_fixed, input int avg, input int cnt);
		stim_row_t r;
		r.c = query_cmd(xl, yl, xh, yh);
		r.has_fixed = has_fixed;
		r.fixed.average = avg;
		r.fixed.matched_count = CNT_W'(cnt);
		return r;
	endfunction

	// update the shadow table; a query yields the truncated mean of matching stations
	function automatic void apply_command(input cmd_t c, output bit produces, output result_t r);
		longint sum;
		int matched;
		produces = 1'b0;
		r = '0;
		if (c.op == OP_LOAD) begin
			if (known_count < MAX_STATIONS) begin
				known_x[known_count] = int'(c.point_x);
				known_y[known_count] = int'(c.point_y);
				known_temp[known_count] = int'(c.temperature);
				known_count++;
			end
		end else begin
			sum = 0;
			matched = 0;
			for (int i = 0; i < known_count; i++) begin
				if (known_x[i] >= int'(c.query_x_low) && known_x[i] <= int'(c.query_x_high) &&
						known_y[i] >= int'(c.query_y_low) && known_y[i] <= int'(c.query_y_high)) begin
					matched++;
					sum += longint'(known_temp[i]);
				end
			end
			r.average = (matched != 0) ? int'(sum / longint'(matched)) : 0;
			r.matched_count = matched[CNT_W-1:0];
			produces = 1'b1;
		end
	endfunction

	task automatic drive_command(input cmd_t c, input bit has_fixed, input result_t fixed,
			input int gap);
		bit produces;
		result_t predicted;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		// transfer happens at the first edge with busy low
		do @(posedge clk); while (busy);
		apply_command(c, produces, predicted);
		if (has_fixed)
			awaited_results.push_back(fixed);
		else if (produces)
			awaited_results.push_back(predicted);
	endtask

	task automatic wait_for_results();
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t head;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, average %0d, matched_count %0d",
					$time, result.average, result.matched_count);
				mismatch_count++;
			end else begin
				head = awaited_results.pop_front();
				if (result.average !== head.average) begin
					$display("%0t: average expected %0d, got %0d",
						$time, head.average, result.average);
					mismatch_count++;
				end
				if (result.matched_count !== head.matched_count) begin
					$display("%0t: matched_count expected %0d, got %0d",
						$time, head.matched_count, result.matched_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000ns;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		bit burst;
		int gap;
		int wait_cycles;
		cmd_t c;
		mismatch_count = 0;
		known_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows.push_back(query_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, 0, 0));
		directed_rows.push_back(load_row(COORD_MIN, COORD_MIN, COORD_MIN));
		directed_rows.push_back(load_row(COORD_MAX, COORD_MAX, COORD_MAX));
		// mean of -1 over two stations truncates to zero
		directed_rows.push_back(query_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, 0, 2));
		directed_rows.push_back(query_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1,
			COORD_MIN, 1));
		directed_rows.push_back(query_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1,
			COORD_MAX, 1));
		directed_rows.push_back(query_row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1, 0, 0));
		directed_rows.push_back(query_row(COORD_MIN, 0, COORD_MAX, -1, 1, 0, 0));
		directed_rows.push_back(load_row(5, -5, 3));
		directed_rows.push_back(load_row(5, -5, 4));
		directed_rows.push_back(query_row(5, -5, 5, -5, 1, 3, 2));
		directed_rows.push_back(load_row(-3, 3, -3));
		directed_rows.push_back(load_row(-3, 3, -4));
		directed_rows.push_back(query_row(-3, 3, -3, 3, 1, -3, 2));
		directed_rows.push_back(load_row(0, 0, COORD_MIN));
		directed_rows.push_back(load_row(0, 0, COORD_MIN));
		directed_rows.push_back(query_row(0, 0, 0, 0, 1, COORD_MIN, 2));
		directed_rows.push_back(query_row(-5, -5, 5, 5, 0, 0, 0));
		directed_rows.push_back(query_row(-4, -6, 6, -4, 0, 0, 0));
		directed_rows.push_back(load_row(6, -6, 100));
		directed_rows.push_back(query_row(-4, -6, 5, 6, 0, 0, 0));
		directed_rows.push_back(query_row(-6, -6, 6, 6, 0, 0, 0));
		directed_rows.push_back(query_row(1, -4, 4, 4, 1, 0, 0));

		foreach (directed_rows[i])
			drive_command(directed_rows[i].c, directed_rows[i].has_fixed,
				directed_rows[i].fixed, $urandom_range(0, 9));

		burst = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				burst = ($urandom_range(0, 2) == 0);
			gap = burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 99) < 55)
				c = load_cmd(rand_coord(), rand_coord(), rand_temp());
			else
				c = rand_query();
			drive_command(c, 1'b0, '0, gap);
		end

		// hold off until the block has drained
		start <= 1'b0;
		@(posedge clk);
		wait_for_results();

		// closing mix of loads, full-range and random queries
		for (int n = 0; n < CLOSING_QUERIES; n++) begin
			if (n % 4 == 0)
				drive_command(load_cmd(rand_coord(), rand_coord(), rand_temp()), 1'b0, '0,
					$urandom_range(0, 9));
			if (n % 5 == 0)
				c = query_cmd(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
			else
				c = rand_query();
			drive_command(c, 1'b0, '0, $urandom_range(0, 9));
		end

		start <= 1'b0;
		wait_cycles = 0;
		while (awaited_results.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, awaited_results.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
